>>> rtl/cascaded_range_remap_macros.svh
`ifndef CASCADED_RANGE_REMAP_MACROS_SVH
`define CASCADED_RANGE_REMAP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CRR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("remap check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define CRR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("remap check failed");

`endif

>>> rtl/crr_pkg.sv
package crr_pkg;

    localparam int FIELD_W    = 32;
    localparam int STAGE_W    = 3;
    localparam int ENTRY_W    = 6;

    localparam int STAGE_LSB  = 0;
    localparam int ENTRY_LSB  = STAGE_LSB + STAGE_W;
    localparam int ON_LSB     = ENTRY_LSB + ENTRY_W;
    localparam int DEST_LSB   = ON_LSB + 1;
    localparam int SRC_LSB    = DEST_LSB + FIELD_W;
    localparam int SPAN_LSB   = SRC_LSB + FIELD_W;
    localparam int VALUE_LSB  = SPAN_LSB + FIELD_W;

    localparam int IN_DATA_W  = 144;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 32;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_XLATE = 1'b1;

    typedef logic [FIELD_W-1:0] field_t;

endpackage

>>> rtl/crr_table.sv
module crr_table #(
    parameter int DEPTH  = 448,
    parameter int ADDR_W = 9,
    parameter int WORD_W = 97
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/crr_match.sv
module crr_match #(
    parameter int VALUE_BITS = 32
) (
    input  logic [VALUE_BITS-1:0] v,
    input  logic                  entry_valid,
    input  logic [VALUE_BITS-1:0] dest,
    input  logic [VALUE_BITS-1:0] src,
    input  logic [VALUE_BITS-1:0] span,
    output logic                  hit,
    output logic [VALUE_BITS-1:0] mapped
);

    logic [VALUE_BITS-1:0] offset;

    always_comb
    begin
        offset = v - src;
        hit    = entry_valid && (v >= src) && (offset < span);
        mapped = dest + offset;
    end

endmodule

>>> rtl/cascaded_range_remap.sv
// One item is in work at a time; a load is written in its accept cycle and gives no result.
// A translate reads one entry per cycle, stopping at the first hit of each stage; its result
// is registered once the last stage is done, waiting in a hold state while the output register
// stays full, and the block then returns to idle, ready for the next transfer.
// Reset is asynchronous and active low; after release a clearing pass over all STAGES*ENTRIES
// entries (448 by default) marks every entry invalid, and no input is accepted meanwhile.
`include "cascaded_range_remap_macros.svh"

module cascaded_range_remap #(
    parameter int STAGES     = 7,
    parameter int ENTRIES    = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // stage, entry, entry_on, dest_base, src_base, span, value, zero padding
    input  logic [crr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // op
    input  logic [crr_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // mapped
    output logic [crr_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    import crr_pkg::*;

    localparam int SLOTS  = STAGES * ENTRIES;
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SW     = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int EW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WORD_W = 3 * VALUE_BITS + 1;
    localparam int VB     = VALUE_BITS;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [VB-1:0]     v_reg, v_next;
    logic [SW-1:0]     tag_stage_reg, tag_stage_next;
    logic [EW-1:0]     tag_entry_reg, tag_entry_next;
    logic              m_valid_reg, m_valid_next;
    field_t            out_data_reg, out_data_next;

    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [WORD_W-1:0] wr_data, rd_data;

    logic              hit;
    logic [VB-1:0]     mapped;
    logic [VB-1:0]     v_new;
    logic              advance, out_free, accept;
    logic [SW-1:0]     stage_n;
    logic [EW-1:0]     entry_n;

    logic [STAGE_W-1:0] in_stage;
    logic [ENTRY_W-1:0] in_entry;
    logic               in_on;
    field_t             in_dest, in_src, in_span, in_value;

    assign in_stage = s_axis_tdata[STAGE_LSB +: STAGE_W];
    assign in_entry = s_axis_tdata[ENTRY_LSB +: ENTRY_W];
    assign in_on    = s_axis_tdata[ON_LSB];
    assign in_dest  = s_axis_tdata[DEST_LSB +: FIELD_W];
    assign in_src   = s_axis_tdata[SRC_LSB +: FIELD_W];
    assign in_span  = s_axis_tdata[SPAN_LSB +: FIELD_W];
    assign in_value = s_axis_tdata[VALUE_LSB +: FIELD_W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    crr_table #(
        .DEPTH  (SLOTS),
        .ADDR_W (ADDR_W),
        .WORD_W (WORD_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    crr_match #(
        .VALUE_BITS (VB)
    ) u_match (
        .v           (v_reg),
        .entry_valid (rd_data[WORD_W-1]),
        .dest        (rd_data[2*VB +: VB]),
        .src         (rd_data[VB +: VB]),
        .span        (rd_data[0 +: VB]),
        .hit         (hit),
        .mapped      (mapped)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        v_next         = v_reg;
        tag_stage_next = tag_stage_reg;
        tag_entry_next = tag_entry_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_addr        = clr_reg;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        out_free       = !m_valid_reg || m_axis_tready;
        v_new          = hit ? mapped : v_reg;
        advance        = hit || (tag_entry_reg == EW'(ENTRIES - 1));
        stage_n        = advance ? SW'(tag_stage_reg + 1'b1) : tag_stage_reg;
        entry_n        = advance ? '0 : EW'(tag_entry_reg + 1'b1);

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                if (clr_reg == ADDR_W'(SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = ADDR_W'(clr_reg + 1'b1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tuser[0] == OP_XLATE)
                    begin
                        v_next         = VB'(in_value);
                        tag_stage_next = '0;
                        tag_entry_next = '0;
                        rd_en          = 1'b1;
                        rd_addr        = '0;
                        state_next     = ST_WALK;
                    end
                    else if ((int'(in_stage) < STAGES) && (int'(in_entry) < ENTRIES))
                    begin
                        wr_en   = 1'b1;
                        wr_addr = ADDR_W'(int'(in_stage) * ENTRIES + int'(in_entry));
                        wr_data = {in_on, VB'(in_dest), VB'(in_src), VB'(in_span)};
                    end
                end
            end
            ST_WALK:
            begin
                if (advance && (tag_stage_reg == SW'(STAGES - 1)))
                begin
                    v_next = v_new;
                    if (out_free)
                    begin
                        m_valid_next  = 1'b1;
                        out_data_next = FIELD_W'(v_new);
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
                else
                begin
                    v_next         = v_new;
                    tag_stage_next = stage_n;
                    tag_entry_next = entry_n;
                    rd_en          = 1'b1;
                    rd_addr        = ADDR_W'(int'(stage_n) * ENTRIES + int'(entry_n));
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    out_data_next = FIELD_W'(v_reg);
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg         <= v_next;
        tag_stage_reg <= tag_stage_next;
        tag_entry_reg <= tag_entry_next;
        out_data_reg  <= out_data_next;
    end

    `CRR_ASSERT_SAME(a_no_write_in_walk, state_reg == ST_WALK, !wr_en)
    `CRR_ASSERT_NEXT(a_xlate_starts_walk, accept && (s_axis_tuser[0] == OP_XLATE),
                     state_reg == ST_WALK)
    `CRR_ASSERT_SAME(a_hold_needs_full_output, state_reg == ST_HOLD, m_valid_reg)
    `CRR_ASSERT_SAME(a_walk_tag_in_range, state_reg == ST_WALK,
                     (int'(tag_entry_reg) < ENTRIES) && (int'(tag_stage_reg) < STAGES))

endmodule
